### hw/rtl/sha256sh_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package sha256sh_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned FillBits   = 6;

  localparam logic [FillBits-1:0] FILL_LAST = 6'd63;
  localparam logic [5:0]          ROUND_LAST = 6'd63;
  localparam logic [2:0]          WORD_LAST  = 3'd7;
  localparam logic [7:0]          PAD_MARK   = 8'h80;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_PAD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic absorb;       // shift the input byte in and count it
    logic pad_shift;    // shift a padding byte in
    logic pad_first;    // this padding byte is the end marker
    logic len_blk_set;  // the next block carries the length field
    logic start;        // load schedule window and working variables
    logic round;        // run one compression round
    logic finish;       // fold working variables into the hash
    logic word_adv;     // digest word taken
    logic msg_clear;    // back to the initial message state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FillBits-1:0] fill;
    logic                len_blk;
    logic                round_last;
    logic                word_last;
  } sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                     input logic [31:0] g);
    ch = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c);
    maj = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

### hw/rtl/sha256sh_ctrl.sv
// Sequencing state machine for the SHA-256 stream hasher.
// Depends on sha256sh_pkg; drives the datapath through cmd_t, watches sts_t.
`timescale 1ns / 1ps

module sha256sh_ctrl
  import sha256sh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic byte_present_i,
  input  logic end_of_message_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   eom_pend_q, eom_pend_d;
  logic   pad_started_q, pad_started_d;
  logic   final_q, final_d;
  logic   in_acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    eom_pend_d    = eom_pend_q;
    pad_started_d = pad_started_q;
    final_d       = final_q;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.absorb = byte_present_i;
          if (byte_present_i && (sts_i.fill == FILL_LAST)) begin
            state_d    = ST_LOAD;
            eom_pend_d = end_of_message_i;
            final_d    = 1'b0;
          end else if (end_of_message_i) begin
            state_d       = ST_PAD;
            pad_started_d = 1'b0;
          end
        end
      end
      ST_PAD: begin
        cmd_o.pad_shift = 1'b1;
        cmd_o.pad_first = !pad_started_q;
        pad_started_d   = 1'b1;
        if (sts_i.fill == FILL_LAST) begin
          state_d = ST_LOAD;
          final_d = pad_started_q && sts_i.len_blk;
        end
      end
      ST_LOAD: begin
        cmd_o.start = 1'b1;
        state_d     = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (sts_i.round_last) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.finish = 1'b1;
        if (final_q) begin
          state_d = ST_OUT;
        end else if (pad_started_q) begin
          // marker block overflowed: length goes in a block of its own
          cmd_o.len_blk_set = 1'b1;
          state_d           = ST_PAD;
        end else if (eom_pend_q) begin
          eom_pend_d = 1'b0;
          state_d    = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          cmd_o.word_adv = 1'b1;
          if (sts_i.word_last) begin
            cmd_o.msg_clear = 1'b1;
            eom_pend_d      = 1'b0;
            pad_started_d   = 1'b0;
            final_d         = 1'b0;
            state_d         = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      eom_pend_q    <= 1'b0;
      pad_started_q <= 1'b0;
      final_q       <= 1'b0;
    end else begin
      state_q       <= state_d;
      eom_pend_q    <= eom_pend_d;
      pad_started_q <= pad_started_d;
      final_q       <= final_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output handshakes open together");

  a_full_block_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && byte_present_i && (sts_i.fill == FILL_LAST)) |=> (state_q == ST_LOAD))
    else $error("full block did not start a compression");

  a_rounds_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && sts_i.round_last) |=> (state_q == ST_ADD))
    else $error("compression ran past the last round");

  a_final_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD && final_q) |=> (out_valid_o && !sts_i.fill[0] && sts_i.fill == '0))
    else $error("final compression did not lead to digest output");
`endif

endmodule

### hw/rtl/sha256sh_dp.sv
// Datapath of the SHA-256 stream hasher: block shift line, schedule window,
// round logic, hash words and length counter. Depends on sha256sh_pkg.
`timescale 1ns / 1ps

module sha256sh_dp
  import sha256sh_pkg::*;
#(
  parameter int unsigned LENGTH_COUNTER_BITS = 61
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [7:0]  data_byte_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_last_o
);

  logic [8*BlockBytes-1:0]        blk_q, blk_d;
  logic [FillBits-1:0]            fill_q, fill_d;
  logic [LENGTH_COUNTER_BITS-1:0] cnt_q, cnt_d;
  logic                           len_blk_q, len_blk_d;
  logic [5:0]                     rnd_q, rnd_d;
  logic [2:0]                     widx_q, widx_d;
  logic [31:0]                    win_q [16];
  logic [31:0]                    win_d [16];
  logic [31:0]                    wv_q [8];
  logic [31:0]                    wv_d [8];
  logic [31:0]                    hash_q [8];
  logic [31:0]                    hash_d [8];

  logic [63:0] len_bits;
  logic [7:0]  len_byte, pad_byte, shift_byte;
  logic [31:0] w_next, t1, t2;

  // length field, written big-endian at block offsets 56..63
  assign len_bits = {{(64 - LENGTH_COUNTER_BITS){1'b0}}, cnt_q} << 3;
  assign len_byte = 8'(len_bits >> {~fill_q[2:0], 3'b000});

  always_comb begin
    if (cmd_i.pad_first) begin
      pad_byte = PAD_MARK;
    end else if (len_blk_q && (fill_q[5:3] == 3'b111)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign shift_byte = cmd_i.absorb ? data_byte_i : pad_byte;

  assign w_next = small_s1(win_q[14]) + win_q[9] + small_s0(win_q[1]) + win_q[0];
  assign t1 = wv_q[7] + big_s1(wv_q[4]) + ch(wv_q[4], wv_q[5], wv_q[6]) + ROUND_K[rnd_q]
            + win_q[0];
  assign t2 = big_s0(wv_q[0]) + maj(wv_q[0], wv_q[1], wv_q[2]);

  always_comb begin
    blk_d     = blk_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    len_blk_d = len_blk_q;
    rnd_d     = rnd_q;
    widx_d    = widx_q;
    win_d     = win_q;
    wv_d      = wv_q;
    hash_d    = hash_q;

    if (cmd_i.absorb || cmd_i.pad_shift) begin
      blk_d  = {blk_q[8*BlockBytes-9:0], shift_byte};
      fill_d = fill_q + 1'b1;
    end
    if (cmd_i.absorb) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.pad_first) begin
      len_blk_d = (fill_q[5:3] != 3'b111);
    end
    if (cmd_i.len_blk_set) begin
      len_blk_d = 1'b1;
    end

    if (cmd_i.start) begin
      for (int i = 0; i < 16; i++) begin
        win_d[i] = blk_q[8*BlockBytes-1-32*i -: 32];
      end
      wv_d  = hash_q;
      rnd_d = '0;
    end
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = w_next;
      wv_d[7]   = wv_q[6];
      wv_d[6]   = wv_q[5];
      wv_d[5]   = wv_q[4];
      wv_d[4]   = wv_q[3] + t1;
      wv_d[3]   = wv_q[2];
      wv_d[2]   = wv_q[1];
      wv_d[1]   = wv_q[0];
      wv_d[0]   = t1 + t2;
      rnd_d     = rnd_q + 1'b1;
    end
    if (cmd_i.finish) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + wv_q[i];
      end
    end

    if (cmd_i.word_adv) begin
      widx_d = widx_q + 1'b1;
    end
    if (cmd_i.msg_clear) begin
      hash_d    = HASH_INIT;
      fill_d    = '0;
      cnt_d     = '0;
      len_blk_d = 1'b0;
      widx_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      cnt_q     <= '0;
      len_blk_q <= 1'b0;
      rnd_q     <= '0;
      widx_q    <= '0;
      hash_q    <= HASH_INIT;
    end else begin
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      len_blk_q <= len_blk_d;
      rnd_q     <= rnd_d;
      widx_q    <= widx_d;
      hash_q    <= hash_d;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    win_q <= win_d;
    wv_q  <= wv_d;
  end

  assign sts_o.fill       = fill_q;
  assign sts_o.len_blk    = len_blk_q;
  assign sts_o.round_last = (rnd_q == ROUND_LAST);
  assign sts_o.word_last  = (widx_q == WORD_LAST);

  assign digest_word_o = hash_q[widx_q];
  assign word_index_o  = widx_q;
  assign digest_last_o = (widx_q == WORD_LAST);

endmodule

### hw/rtl/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher: one message byte per input beat, digest out as eight word beats.
// Byte beats are taken back to back; the 64th byte of a block stalls the input for a compression
// (load, 64 rounds, add). End of message: 64 - fill padding shifts (64 more if the length needs its
// own block), one or two compressions, then 8 output beats at one per cycle of out_ready_i.
// Reset (async, active low): hash words to the initial values, byte count and fill to zero.
// The block buffer and round registers are not reset; padding never reads a stale byte.
`timescale 1ns / 1ps

module sha256_stream_hasher_unit
  import sha256sh_pkg::*;
#(
  parameter int unsigned LENGTH_COUNTER_BITS = 61
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats: one byte, or an end mark, or both
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  // digest beats, word 0 first
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_last_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller takes a beat only in its idle state; bytes shift straight into the
  // block line, so the rate limit is the single shared round unit in the datapath.
  sha256sh_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sts_i            (sts),
    .cmd_o            (cmd)
  );

  // Holds the hash words, so the digest beats come straight from registers.
  sha256sh_dp #(
    .LENGTH_COUNTER_BITS (LENGTH_COUNTER_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (data_byte_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .digest_last_o (digest_last_o)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for sha256_stream_hasher_unit: byte beats in, digest word beats out.
// Holds its own SHA-256 predictor and needs only the hasher RTL and sha256sh_pkg.
`timescale 1ns / 1ps

module tb_top;

  // Narrow length counter
  localparam int unsigned CountBits = 16;
  // Quiet cycles after the last digest: covers a full padding pass and two compressions
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned LongHoldCycles = 600;
  localparam int unsigned RandomItems = 160;
  localparam logic [7:0] PadByte = 8'h80;
  localparam int unsigned LastWord = 7;

  localparam logic [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One input beat as queued for the driver; gap is the idle time after it is taken
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
    logic [7:0] gap;
  } byte_beat_t;

  // One expected digest word beat
  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        byte_present_i = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        digest_last_o;

  byte_beat_t   byte_q [$];
  digest_beat_t digest_q [$];

  // Predictor state: running hash, partial block and byte count of the open message
  logic [31:0]          hash_acc [8];
  logic [7:0]           blk_bytes [64];
  logic [CountBits-1:0] msg_bytes;

  int unsigned err_cnt = 0;
  int unsigned digests_seen = 0;
  bit          in_taken = 1'b0;
  int unsigned in_hold = 0;
  int unsigned out_stall = 0;
  int unsigned long_hold = 0;
  bit          squeeze_done = 1'b0;
  int unsigned cyc_cnt = 0;

  sha256_stream_hasher_unit #(
    .LENGTH_COUNTER_BITS(CountBits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .byte_present_i  (byte_present_i),
    .end_of_message_i(end_of_message_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .digest_word_o   (digest_word_o),
    .word_index_o    (word_index_o),
    .digest_last_o   (digest_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  // Start a fresh message: initial hash words, empty block, zero count
  function automatic void restart_message();
    for (int k = 0; k < 8; k++) hash_acc[k] = IV_WORDS[k];
    for (int k = 0; k < 64; k++) blk_bytes[k] = 8'h00;
    msg_bytes = '0;
  endfunction

  // Run the 64 rounds over blk_bytes and fold the result into hash_acc
  function automatic void fold_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, lo, hi;
    for (int r = 0; r < 16; r++)
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    for (int r = 0; r < 8; r++) v[r] = hash_acc[r];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        hi = w[(r - 2) % 16];
        lo = w[(r - 15) % 16];
        wt = (ror32(hi, 17) ^ ror32(hi, 19) ^ (hi >> 10)) + w[(r - 7) % 16]
           + (ror32(lo, 7) ^ ror32(lo, 18) ^ (lo >> 3)) + w[r % 16];
        w[r % 16] = wt;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[r] + wt;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int r = 0; r < 8; r++) hash_acc[r] = hash_acc[r] + v[r];
  endfunction

  // Absorb one accepted beat; on the end mark pad, finish and queue the eight digest words
  function automatic void hash_beat(input logic [7:0] b, input logic present,
                                    input logic eom);
    int unsigned  fill;
    logic [63:0]  bit_len;
    digest_beat_t d;
    if (present) begin
      blk_bytes[msg_bytes[5:0]] = b;
      msg_bytes = msg_bytes + 1'b1;
      if (msg_bytes[5:0] == 6'd0) fold_block();
    end
    if (eom) begin
      fill = msg_bytes[5:0];
      blk_bytes[fill] = PadByte;
      fill++;
      // No room for the length field: close this block and pad a second one
      if (fill > 56) begin
        for (int k = fill; k < 64; k++) blk_bytes[k] = 8'h00;
        fold_block();
        fill = 0;
      end
      for (int k = fill; k < 56; k++) blk_bytes[k] = 8'h00;
      bit_len = 64'(msg_bytes) << 3;
      for (int k = 0; k < 8; k++) blk_bytes[56 + k] = bit_len[8 * (7 - k) +: 8];
      fold_block();
      for (int k = 0; k < 8; k++) begin
        d.word = hash_acc[k];
        d.idx  = 3'(k);
        d.last = (k == LastWord);
        digest_q.push_back(d);
      end
      restart_message();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    digest_beat_t exp_d;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) hash_beat(data_byte_i, byte_present_i, end_of_message_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        report_mismatch("digest beat with nothing pending", digest_word_o, 32'h0);
      end else begin
        exp_d = digest_q.pop_front();
        if (digest_word_o !== exp_d.word)
          report_mismatch("digest_word", digest_word_o, exp_d.word);
        if (word_index_o !== exp_d.idx)
          report_mismatch("word_index", 32'(word_index_o), 32'(exp_d.idx));
        if (digest_last_o !== exp_d.last)
          report_mismatch("digest_last", 32'(digest_last_o), 32'(exp_d.last));
      end
      if (digest_last_o) digests_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: change inputs at the falling edge, one assignment per signal per edge
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    byte_beat_t cur;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      // Slot is free: wait out the gap, then offer the next beat
      if (in_hold > 0) begin
        in_hold--;
        in_valid_i <= 1'b0;
      end else if (byte_q.size() != 0) begin
        cur = byte_q.pop_front();
        in_valid_i       <= 1'b1;
        data_byte_i      <= cur.data;
        byte_present_i   <= cur.present;
        end_of_message_i <= cur.eom;
        in_hold = cur.gap;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off to back up the input
  always @(negedge clk_i) begin
    cyc_cnt++;
    if (long_hold > 0) begin
      long_hold--;
      out_ready_i <= 1'b0;
    end else if (!squeeze_done && digests_seen >= 2 && out_valid_o) begin
      // Hold a pending digest while the sender keeps offering the next message
      squeeze_done = 1'b1;
      long_hold = LongHoldCycles;
      out_ready_i <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else if (cyc_cnt[8:7] != 2'b01 && $urandom_range(99) < 25) begin
      out_stall = ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(60, 20);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 60) pick_gap = 8'd0;
    else if (r < 90)    pick_gap = 8'($urandom_range(3, 1));
    else                pick_gap = 8'($urandom_range(40, 8));
  endfunction

  function automatic void push_beat(input logic [7:0] b, input logic present,
                                    input logic eom, input logic [7:0] gap);
    byte_beat_t nb;
    nb.data    = b;
    nb.present = present;
    nb.eom     = eom;
    nb.gap     = gap;
    byte_q.push_back(nb);
  endfunction

  // Queue one message of random bytes; return the number of beats queued
  function automatic int unsigned add_message(input int unsigned len, input bit end_alone,
                                              input bit calm, input bit noisy);
    int unsigned n;
    n = 0;
    for (int k = 0; k < len; k++) begin
      // Drop in an empty beat now and then: the block must ignore it
      if (noisy && $urandom_range(11) == 0) begin
        push_beat(8'($urandom), 1'b0, 1'b0, pick_gap(calm));
        n++;
      end
      push_beat(8'($urandom), 1'b1, (k == len - 1) && !end_alone, pick_gap(calm));
      n++;
    end
    if (end_alone || len == 0) begin
      push_beat(8'($urandom), 1'b0, 1'b1, pick_gap(calm));
      n++;
    end
    return n;
  endfunction

  initial begin
    int unsigned rand_items;
    int unsigned len, r;
    restart_message();

    // Directed: empty message, an ignored beat, byte with end mark, byte extremes,
    // an end-only beat after bytes, and a short text message
    push_beat(8'hff, 1'b0, 1'b1, 8'd0);
    push_beat(8'hff, 1'b0, 1'b0, 8'd0);
    push_beat(8'h00, 1'b1, 1'b1, 8'd0);
    push_beat(8'hff, 1'b1, 1'b0, 8'd2);
    push_beat(8'h80, 1'b1, 1'b0, 8'd0);
    push_beat(8'h00, 1'b0, 1'b1, 8'd1);
    push_beat(8'h61, 1'b1, 1'b0, 8'd0);
    push_beat(8'h62, 1'b1, 1'b0, 8'd0);
    push_beat(8'h63, 1'b1, 1'b1, 8'd0);

    // Random: mostly short messages, many close to a block edge, a few longer
    rand_items = 0;
    while (rand_items < RandomItems) begin
      r = $urandom_range(99);
      if (r < 40)      len = $urandom_range(8, 0);
      else if (r < 70) len = $urandom_range(68, 52);
      else if (r < 85) len = $urandom_range(51, 9);
      else if (r < 95) len = $urandom_range(130, 119);
      else             len = 0;
      // Keep the total close to the planned item count
      if (len > RandomItems - rand_items) len = RandomItems - rand_items;
      rand_items += add_message(len, $urandom_range(2) == 0, $urandom_range(3) == 0, 1'b1);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: all beats offered and taken, all digests back, then let the block settle
    while (byte_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("sha256_stream_hasher_unit test passed");
    end else begin
      $display("sha256_stream_hasher_unit test failed");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("sha256_stream_hasher_unit test failed");
    $finish;
  end

endmodule
